// File: hw/rtl/sc2a_pkg.sv
`timescale 1ns / 1ps
// Shared types, scan code constants and character tables for the scan code line editor.
// No dependencies.
package sc2a_pkg;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CHAR  = 2'd1,
        EV_NEWLN = 2'd2,
        EV_ERASE = 2'd3
    } t_event_kind;

    typedef struct packed {
        logic shift;
        logic caps;
    } t_mods;

    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_TAB       = 8'h0F;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;

    function automatic logic [6:0] keymap(input logic [6:0] code);
        logic [6:0] c;
        c = 7'h00;
        unique case (code)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1A: c = 7'h5B;
            7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h27: c = 7'h3B;
            7'h28: c = 7'h27;
            7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            7'h4A: c = 7'h2D;
            7'h4E: c = 7'h2B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shifted_symbol(input logic [6:0] c);
        logic [6:0] s;
        s = c;
        unique case (c)
            7'h60: s = 7'h7E;
            7'h31: s = 7'h21;
            7'h32: s = 7'h40;
            7'h33: s = 7'h23;
            7'h34: s = 7'h24;
            7'h35: s = 7'h25;
            7'h36: s = 7'h5E;
            7'h37: s = 7'h26;
            7'h38: s = 7'h2A;
            7'h39: s = 7'h28;
            7'h30: s = 7'h29;
            7'h2D: s = 7'h5F;
            7'h3D: s = 7'h2B;
            7'h5B: s = 7'h7B;
            7'h5D: s = 7'h7D;
            7'h5C: s = 7'h7C;
            7'h3B: s = 7'h3A;
            7'h27: s = 7'h22;
            7'h2C: s = 7'h3C;
            7'h2E: s = 7'h3E;
            7'h2F: s = 7'h3F;
            default: s = c;
        endcase
        return s;
    endfunction

    function automatic logic is_lower(input logic [6:0] c);
        return (c >= 7'h61) && (c <= 7'h7A);
    endfunction

    function automatic logic is_letter(input logic [6:0] c);
        return is_lower(c) || ((c >= 7'h41) && (c <= 7'h5A));
    endfunction

    function automatic logic [6:0] to_upper(input logic [6:0] c);
        return is_lower(c) ? (c - 7'd32) : c;
    endfunction

endpackage

// File: hw/rtl/sc2a_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for scan code requests and editor events.
// Depends on sc2a_pkg.
interface sc2a_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink (input valid, input scan_code, output ready);
endinterface

interface sc2a_event_if;
    logic                     valid;
    logic                     ready;
    sc2a_pkg::t_event_kind    event_kind;
    logic [6:0]               ascii_char;

    modport source (output valid, output event_kind, output ascii_char, input ready);
    modport sink (input valid, input event_kind, input ascii_char, output ready);
endinterface

// File: hw/rtl/sc2a_translate.sv
`timescale 1ns / 1ps
// Set-1 make code to ASCII lookup with the shift and caps-lock rules applied.
// Depends on sc2a_pkg for the key table and symbol functions.
module sc2a_translate (
    input  logic [6:0]      i_code,
    input  sc2a_pkg::t_mods i_mods,
    output logic [6:0]      o_char
);

    logic [6:0] w_base;

    assign w_base = sc2a_pkg::keymap(i_code);

    always_comb begin
        priority if (i_mods.caps) begin
            o_char = i_mods.shift ? sc2a_pkg::shifted_symbol(w_base)
                                  : sc2a_pkg::to_upper(w_base);
        end else if (i_mods.shift) begin
            o_char = sc2a_pkg::is_letter(w_base) ? sc2a_pkg::to_upper(w_base)
                                                 : sc2a_pkg::shifted_symbol(w_base);
        end else begin
            o_char = w_base;
        end
    end

endmodule

// File: hw/rtl/scancode_to_ascii_line_editor_core.sv
`timescale 1ns / 1ps
// Scan code line editor top level: input register, key decode, result register.
// Depends on sc2a_pkg, sc2a_if and sc2a_translate.
//
// Usage:
//   i_code carries one raw set-1 scan code per request; bit 7 marks a release.
//   o_event returns exactly one event per request: nothing, a character,
//   a newline (line cleared) or an erase of the last character.
//   A request accepted into the input register is decoded there against the
//   shift, caps and line length state, and the event lands in the result
//   register, from which it can be taken.
//   One request per cycle unless o_event stalls; the key table lookup, the case
//   rules and the line length compare sit in one combinational stage.
//   When o_event stalls, the result register holds, the input register fills
//   behind it, and i_code.ready drops until the result is taken.
//   Reset (synchronous, active low) releases both shifts, clears caps lock,
//   empties the line and drops both valid flags.
//   LINE_MAX sets the longest line; characters beyond it are dropped.
module scancode_to_ascii_line_editor_core #(
    parameter int LINE_MAX = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sc2a_code_if.sink           i_code,
    sc2a_event_if.source        o_event
);

    localparam int                LEN_W   = $clog2(LINE_MAX + 1);
    localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(LINE_MAX);

    logic                   r_s1_valid;
    logic [7:0]             r_s1_code;
    logic                   r_out_valid;
    sc2a_pkg::t_event_kind  r_out_kind;
    logic [6:0]             r_out_char;

    logic                   r_lshift;
    logic                   r_rshift;
    logic                   r_caps;
    logic [LEN_W-1:0]       r_len;

    logic                   n_lshift;
    logic                   n_rshift;
    logic                   n_caps;
    logic [LEN_W-1:0]       n_len;
    sc2a_pkg::t_event_kind  n_kind;
    logic [6:0]             n_char;

    logic                   w_s1_fire;
    logic                   w_in_fire;
    sc2a_pkg::t_mods        w_mods;
    logic [6:0]             w_char;

    assign w_s1_fire      = r_s1_valid && (!r_out_valid || o_event.ready);
    assign i_code.ready   = !r_s1_valid || w_s1_fire;
    assign w_in_fire      = i_code.valid && i_code.ready;

    assign w_mods.shift   = r_lshift || r_rshift;
    assign w_mods.caps    = r_caps;

    sc2a_translate u_translate (
        .i_code (r_s1_code[6:0]),
        .i_mods (w_mods),
        .o_char (w_char)
    );

    always_comb begin
        n_lshift = r_lshift;
        n_rshift = r_rshift;
        n_caps   = r_caps;
        n_len    = r_len;
        n_kind   = sc2a_pkg::EV_NONE;
        n_char   = 7'h00;
        unique case (r_s1_code)
            sc2a_pkg::SC_LSHIFT:    n_lshift = 1'b1;
            sc2a_pkg::SC_RSHIFT:    n_rshift = 1'b1;
            sc2a_pkg::SC_LSHIFT_UP: n_lshift = 1'b0;
            sc2a_pkg::SC_RSHIFT_UP: n_rshift = 1'b0;
            sc2a_pkg::SC_CAPS:      n_caps   = !r_caps;
            sc2a_pkg::SC_TAB: begin
            end
            sc2a_pkg::SC_ENTER: begin
                n_kind = sc2a_pkg::EV_NEWLN;
                n_len  = '0;
            end
            sc2a_pkg::SC_BACKSPACE: begin
                if (r_len != '0) begin
                    n_kind = sc2a_pkg::EV_ERASE;
                    n_len  = r_len - LEN_W'(1);
                end
            end
            default: begin
                if (!r_s1_code[7] && (w_char != 7'h00) && (r_len < LEN_MAX)) begin
                    n_kind = sc2a_pkg::EV_CHAR;
                    n_char = w_char;
                    n_len  = r_len + LEN_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lshift    <= 1'b0;
            r_rshift    <= 1'b0;
            r_caps      <= 1'b0;
            r_len       <= '0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
                r_lshift    <= n_lshift;
                r_rshift    <= n_rshift;
                r_caps      <= n_caps;
                r_len       <= n_len;
            end else if (o_event.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_code <= i_code.scan_code;
        end
        if (w_s1_fire) begin
            r_out_kind <= n_kind;
            r_out_char <= n_char;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_out_kind;
    assign o_event.ascii_char = r_out_char;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_MAX)
        else $error("line length above limit");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind != sc2a_pkg::EV_CHAR)) |-> (r_out_char == 7'h00))
        else $error("character set on a non-character event");

    a_erase_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && (n_kind == sc2a_pkg::EV_ERASE))
            |=> (r_len == $past(r_len) - LEN_W'(1)))
        else $error("erase did not shorten the line by one");

    a_newline_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && (n_kind == sc2a_pkg::EV_NEWLN)) |=> (r_len == '0))
        else $error("newline did not clear the line");

    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && (n_kind == sc2a_pkg::EV_CHAR))
            |=> (r_len == $past(r_len) + LEN_W'(1)))
        else $error("character did not extend the line by one");

endmodule

// File: verif/scancode_to_ascii_line_editor_core_test.sv
`timescale 1ns / 1ps
// Testbench for scancode_to_ascii_line_editor_core: scan code requests in, one event per request out.
// Depends on sc2a_pkg, sc2a_if and the core; predicts each event and checks it on arrival.
module scancode_to_ascii_line_editor_core_test;

    localparam int LINE_MAX    = 255;
    localparam int TOTAL_CODES = 1950;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        sc2a_pkg::t_event_kind kind;
        logic [6:0]            ch;
    } t_key_event;

    logic i_clk;
    logic i_rst_n;

    sc2a_code_if  code_bus ();
    sc2a_event_if event_bus ();

    scancode_to_ascii_line_editor_core #(
        .LINE_MAX (LINE_MAX)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (code_bus),
        .o_event (event_bus)
    );

    logic [6:0] key_table [128];
    logic [6:0] shift_table [128];
    logic [7:0] printable_codes [$];

    logic lshift_held;
    logic rshift_held;
    logic caps_on;
    int   line_len;

    t_key_event pending_events [$];
    int mismatch_count;
    int codes_sent;
    int cycle_count;

    int burst_left;
    int burst_max;
    int gap_max;
    int stall_pct;
    int hold_off_len;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scancode_to_ascii_line_editor_core_test: done, errors");
            $finish;
        end
    end

    initial begin
        event_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len > 0) begin
                event_bus.ready <= 1'b0;
                repeat (hold_off_len) @(negedge i_clk);
                hold_off_len = 0;
            end else begin
                event_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_events
        t_key_event want;
        if (i_rst_n && event_bus.valid && event_bus.ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: event_kind %0d ascii_char %0h",
                       event_bus.event_kind, event_bus.ascii_char);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                if (event_bus.event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_bus.event_kind);
                    mismatch_count++;
                end
                if (event_bus.ascii_char !== want.ch) begin
                    $error("ascii_char: expected %0h, got %0h", want.ch, event_bus.ascii_char);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic fill_row(input int base, input string keys);
        for (int i = 0; i < keys.len(); i++) begin
            key_table[base + i] = 7'(keys[i]);
        end
    endtask

    function automatic logic [6:0] upper_case(input logic [6:0] c);
        return (c >= 7'h61 && c <= 7'h7A) ? c - 7'd32 : c;
    endfunction

    function automatic t_key_event predict_event(input logic [7:0] code);
        t_key_event ev;
        logic [6:0] c;
        logic       shift;
        logic       letter;
        ev.kind = sc2a_pkg::EV_NONE;
        ev.ch   = 7'h00;
        shift   = lshift_held | rshift_held;
        case (code)
            sc2a_pkg::SC_LSHIFT:    lshift_held = 1'b1;
            sc2a_pkg::SC_RSHIFT:    rshift_held = 1'b1;
            sc2a_pkg::SC_LSHIFT_UP: lshift_held = 1'b0;
            sc2a_pkg::SC_RSHIFT_UP: rshift_held = 1'b0;
            sc2a_pkg::SC_CAPS:      caps_on = ~caps_on;
            sc2a_pkg::SC_TAB: ;
            sc2a_pkg::SC_ENTER: begin
                ev.kind  = sc2a_pkg::EV_NEWLN;
                line_len = 0;
            end
            sc2a_pkg::SC_BACKSPACE: begin
                if (line_len != 0) begin
                    ev.kind = sc2a_pkg::EV_ERASE;
                    line_len--;
                end
            end
            default: begin
                if (!code[7]) begin
                    c      = key_table[code[6:0]];
                    letter = (c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A);
                    if (caps_on) begin
                        c = shift ? shift_table[c] : upper_case(c);
                    end else if (shift) begin
                        c = letter ? upper_case(c) : shift_table[c];
                    end
                    if (c != 7'h00 && line_len < LINE_MAX) begin
                        ev.kind = sc2a_pkg::EV_CHAR;
                        ev.ch   = c;
                        line_len++;
                    end
                end
            end
        endcase
        return ev;
    endfunction

    task automatic send_code(input logic [7:0] code);
        code_bus.valid     <= 1'b1;
        code_bus.scan_code <= code;
        do @(posedge i_clk); while (!code_bus.ready);
        pending_events.push_back(predict_event(code));
        codes_sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gap_max > 0) begin
            code_bus.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(0, burst_max);
        end
    endtask

    function automatic logic [7:0] any_printable();
        return printable_codes[$urandom_range(0, printable_codes.size() - 1)];
    endfunction

    function automatic logic [7:0] pick_code(input logic long_line);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return any_printable();
        if (r < 60) return any_printable() | 8'h80;
        if (r < 66) return $urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT : sc2a_pkg::SC_RSHIFT;
        if (r < 72) return $urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_UP
                                                : sc2a_pkg::SC_RSHIFT_UP;
        if (r < 74) return sc2a_pkg::SC_CAPS;
        if (r < 77) return long_line ? any_printable() : sc2a_pkg::SC_ENTER;
        if (r < 85) return long_line ? any_printable() : sc2a_pkg::SC_BACKSPACE;
        if (r < 87) return sc2a_pkg::SC_TAB;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_directed_keys();
        logic [7:0] seq [26] = '{
            8'h00, 8'h01, sc2a_pkg::SC_BACKSPACE, sc2a_pkg::SC_TAB, 8'h7F, 8'hFF, 8'h80,
            8'h1E, 8'h02, sc2a_pkg::SC_LSHIFT, 8'h1E, 8'h29, sc2a_pkg::SC_LSHIFT_UP,
            sc2a_pkg::SC_RSHIFT, 8'h0D, sc2a_pkg::SC_RSHIFT_UP, sc2a_pkg::SC_CAPS, 8'h1E,
            8'h02, sc2a_pkg::SC_RSHIFT, 8'h1E, 8'h28, sc2a_pkg::SC_RSHIFT_UP,
            sc2a_pkg::SC_CAPS, sc2a_pkg::SC_BACKSPACE, sc2a_pkg::SC_ENTER
        };
        gap_max   = 2;
        burst_max = 3;
        stall_pct = 20;
        foreach (seq[i]) send_code(seq[i]);
    endtask

    task automatic test_line_full();
        gap_max   = 2;
        burst_max = 6;
        stall_pct = 15;
        send_code(sc2a_pkg::SC_ENTER);
        repeat (LINE_MAX + 4) send_code(any_printable());
        send_code(sc2a_pkg::SC_BACKSPACE);
        send_code(any_printable());
        send_code(any_printable());
        send_code(sc2a_pkg::SC_ENTER);
        send_code(sc2a_pkg::SC_BACKSPACE);
    endtask

    task automatic test_input_stall();
        gap_max      = 0;
        stall_pct    = 0;
        hold_off_len = 64;
        repeat (24) send_code(any_printable());
    endtask

    task automatic test_random_typing();
        int   chunk_len;
        logic long_line;
        while (codes_sent < TOTAL_CODES) begin
            chunk_len = $urandom_range(40, 400);
            if (chunk_len > TOTAL_CODES - codes_sent) chunk_len = TOTAL_CODES - codes_sent;
            long_line = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: begin gap_max = 0; burst_max = 0; stall_pct = 0;  end
                1: begin gap_max = 3; burst_max = 6; stall_pct = 25; end
                2: begin gap_max = 8; burst_max = 2; stall_pct = 60; end
                default: begin gap_max = 1; burst_max = 0; stall_pct = 10; end
            endcase
            repeat (chunk_len) send_code(pick_code(long_line));
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        code_bus.valid     = 1'b0;
        code_bus.scan_code = 8'h00;
        lshift_held        = 1'b0;
        rshift_held        = 1'b0;
        caps_on            = 1'b0;
        line_len           = 0;
        mismatch_count     = 0;
        codes_sent         = 0;
        cycle_count        = 0;
        burst_left         = 0;
        burst_max          = 0;
        gap_max            = 0;
        stall_pct          = 0;
        hold_off_len       = 0;

        foreach (key_table[i]) key_table[i] = 7'h00;
        key_table[8'h01] = 7'h1B;
        fill_row(8'h02, "1234567890-=");
        fill_row(8'h10, "qwertyuiop[]");
        fill_row(8'h1E, "asdfghjkl;'");
        key_table[8'h29] = 7'h60;
        fill_row(8'h2B, "\\zxcvbnm,./");
        key_table[8'h37] = 7'h2A;
        key_table[8'h39] = 7'h20;
        key_table[8'h4A] = 7'h2D;
        key_table[8'h4E] = 7'h2B;

        begin : build_shift_table
            string plain;
            string shifted;
            plain   = "1234567890-=[]\\;',./";
            shifted = "!@#$%^&*()_+{}|:\"<>?";
            foreach (shift_table[i]) shift_table[i] = 7'(i);
            for (int i = 0; i < plain.len(); i++) begin
                shift_table[7'(plain[i])] = 7'(shifted[i]);
            end
            shift_table[7'h60] = 7'h7E;
        end

        for (int c = 0; c < 128; c++) begin
            if (key_table[c] != 7'h00) printable_codes.push_back(8'(c));
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_keys();
        test_line_full();
        test_input_stall();
        test_random_typing();

        code_bus.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("scancode_to_ascii_line_editor_core_test: done, clean");
        end else begin
            $display("scancode_to_ascii_line_editor_core_test: done, errors");
        end
        $finish;
    end
endmodule

// File: scancode_to_ascii_line_editor_core.f
hw/rtl/sc2a_pkg.sv
hw/rtl/sc2a_if.sv
hw/rtl/sc2a_translate.sv
hw/rtl/scancode_to_ascii_line_editor_core.sv
verif/scancode_to_ascii_line_editor_core_test.sv
